// File: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  typedef logic [7:0] byte_t;

  localparam int FRAME_BYTES = 24;
  localparam int WIN_CELLS   = FRAME_BYTES - 1;
  localparam int CHECK_BYTES = 20;
  localparam int WORDS       = CHECK_BYTES / 4;
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_BYTES - 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_END = 2'd2;

  localparam byte_t START_RST   = 8'd83;
  localparam byte_t END_RST     = 8'd10;
  localparam byte_t PRE_END_RST = 8'd13;

  typedef struct packed {
    logic  shift;
    byte_t byte_in;
    byte_t par_in;
  } cell_in_t;

endpackage

// File: sv/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One window byte: shifts towards the older end on each beat and folds its
// byte into the running parity passed along the chain.
// ----------------------------------------------------------------------------
module sfr_cell (
  input  logic              clk,
  input  sfr_pkg::cell_in_t cin,
  output sfr_pkg::byte_t    byte_q,
  output sfr_pkg::byte_t    par_out
);

  always_ff @(posedge clk) begin
    if (cin.shift) begin
      byte_q <= cin.byte_in;
    end
  end

  assign par_out = cin.par_in ^ byte_q;

endmodule

// File: sv/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Finds 24-byte frames in a received byte stream and checks them.
//
// Input channel: one rx_byte per beat (in_valid / in_stall). The last 23
// bytes sit in a row of byte cells; with the incoming byte they form the
// 24-byte window. A frame is found when the window is full, its oldest byte
// equals start_byte and the incoming byte equals end_byte. The window is
// then emptied and 24 more bytes are needed before the next frame.
// Output channel: one beat per frame (out_valid / out_stall) carrying
// frame_good and frame bytes 0..19 as five little-endian words. A frame
// appears on the output the cycle after its last byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the window shift and
// parity check are done in the accepting cycle.
// When a result is held by out_stall, in_stall is raised until it is taken.
// Config: cfg_index/cfg_data writes, always ready; index 3 is ignored.
// Reset: empties the window, drops any pending result and restores
// start 'S', end LF and pre-end CR.
// ----------------------------------------------------------------------------
module serial_frame_receiver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               frame_good,
  output logic [31:0]                        payload_w0,
  output logic [31:0]                        payload_w1,
  output logic [31:0]                        payload_w2,
  output logic [31:0]                        payload_w3,
  output logic [31:0]                        payload_w4,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_data
);

  sfr_pkg::byte_t start_byte;
  sfr_pkg::byte_t end_byte;
  sfr_pkg::byte_t pre_end_byte;

  logic [sfr_pkg::FILL_W-1:0] fill;
  logic [sfr_pkg::FILL_W-1:0] fill_next;

  sfr_pkg::byte_t win [sfr_pkg::WIN_CELLS];
  sfr_pkg::byte_t par [sfr_pkg::WIN_CELLS];
  sfr_pkg::cell_in_t cin [sfr_pkg::WIN_CELLS];

  logic accept;
  logic full;
  logic found;
  logic good;
  logic [31:0] words [sfr_pkg::WORDS];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte   <= sfr_pkg::START_RST;
      end_byte     <= sfr_pkg::END_RST;
      pre_end_byte <= sfr_pkg::PRE_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfr_pkg::CFG_START:   start_byte   <= cfg_data;
        sfr_pkg::CFG_END:     end_byte     <= cfg_data;
        sfr_pkg::CFG_PRE_END: pre_end_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // window cells: cell 0 oldest, last cell fed by the incoming byte
  for (genvar i = 0; i < sfr_pkg::WIN_CELLS; i++) begin : g_cell
    assign cin[i].shift = accept;
    if (i == sfr_pkg::WIN_CELLS - 1) begin : g_tail
      assign cin[i].byte_in = rx_byte;
    end else begin : g_body
      assign cin[i].byte_in = win[i+1];
    end
    if (i < 2) begin : g_head
      assign cin[i].par_in = '0;
    end else begin : g_link
      assign cin[i].par_in = par[i-2];
    end
    sfr_cell u_cell (
      .clk     (clk),
      .cin     (cin[i]),
      .byte_q  (win[i]),
      .par_out (par[i])
    );
  end

  // chains include bytes 20 and 21, so a clean checksum leaves zero
  assign full  = (fill == sfr_pkg::FILL_LAST) || (fill == sfr_pkg::FILL_FULL);
  assign found = accept && full && (win[0] == start_byte) && (rx_byte == end_byte);
  assign good  = (win[sfr_pkg::FRAME_BYTES-2] == pre_end_byte) &&
                 (par[sfr_pkg::CHECK_BYTES] == '0) &&
                 (par[sfr_pkg::CHECK_BYTES+1] == '0);

  for (genvar w = 0; w < sfr_pkg::WORDS; w++) begin : g_word
    assign words[w] = {win[4*w+3], win[4*w+2], win[4*w+1], win[4*w]};
  end

  always_comb begin
    fill_next = fill;
    if (found) begin
      fill_next = '0;
    end else if (accept && fill != sfr_pkg::FILL_FULL) begin
      fill_next = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (found) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (found) begin
      frame_good <= good;
      payload_w0 <= words[0];
      payload_w1 <= words[1];
      payload_w2 <= words[2];
      payload_w3 <= words[3];
      payload_w4 <= words[4];
    end
  end

endmodule

// File: sv/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the serial frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        frame_good,
  input logic [31:0] payload_w0,
  input logic [31:0] payload_w1,
  input logic [31:0] payload_w2,
  input logic [31:0] payload_w3,
  input logic [31:0] payload_w4
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({frame_good, payload_w0, payload_w1,
                                        payload_w2, payload_w3, payload_w4}))
    else $error("stalled result beat changed");

  a_back_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("byte taken while a result is held");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result beat without an accepted byte");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

// File: tb/sv/tb_serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver
// Self-checking bench for the serial frame receiver. Bytes are fed as loose
// noise, truncated frames and whole frames (good and damaged) under several
// start/end/pre-end settings. A scoreboard class mirrors the sliding window,
// predicts every frame report and checks each output beat in order. Both
// channels idle and stall at random; one long output hold-off backs the
// block up into its input.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int SHOW_ERRORS = 10;

  typedef struct packed {
    logic            good;
    logic [4:0][31:0] words;
  } frame_rep_t;

  class frame_scoreboard;
    sfr_pkg::byte_t win [sfr_pkg::FRAME_BYTES];
    int             fill;
    sfr_pkg::byte_t start_b;
    sfr_pkg::byte_t end_b;
    sfr_pkg::byte_t pre_b;
    frame_rep_t     expected_frames [$];
    int             n_bytes;
    int             n_frames;
    int             n_good;
    int             n_errors;

    function new();
      fill     = 0;
      start_b  = sfr_pkg::START_RST;
      end_b    = sfr_pkg::END_RST;
      pre_b    = sfr_pkg::PRE_END_RST;
      n_bytes  = 0;
      n_frames = 0;
      n_good   = 0;
      n_errors = 0;
      foreach (win[k]) win[k] = '0;
    endfunction

    function void set_reg(logic [sfr_pkg::CFG_IDX_W-1:0] idx, sfr_pkg::byte_t v);
      case (idx)
        sfr_pkg::CFG_START:   start_b = v;
        sfr_pkg::CFG_END:     end_b   = v;
        sfr_pkg::CFG_PRE_END: pre_b   = v;
        default: ;
      endcase
    endfunction

    function void note_byte(sfr_pkg::byte_t b);
      frame_rep_t     r;
      sfr_pkg::byte_t ev;
      sfr_pkg::byte_t od;
      n_bytes++;
      if (fill < sfr_pkg::FRAME_BYTES) begin
        win[fill] = b;
        fill++;
      end else begin
        for (int k = 0; k < sfr_pkg::FRAME_BYTES - 1; k++) win[k] = win[k + 1];
        win[sfr_pkg::FRAME_BYTES - 1] = b;
      end
      if (fill == sfr_pkg::FRAME_BYTES && win[0] == start_b &&
          win[sfr_pkg::FRAME_BYTES - 1] == end_b) begin
        ev = '0;
        od = '0;
        for (int k = 0; k < sfr_pkg::CHECK_BYTES; k += 2) begin
          ev ^= win[k];
          od ^= win[k + 1];
        end
        r.good = (win[22] == pre_b) && (win[20] == ev) && (win[21] == od);
        for (int w = 0; w < sfr_pkg::WORDS; w++)
          r.words[w] = {win[4*w + 3], win[4*w + 2], win[4*w + 1], win[4*w]};
        expected_frames.push_back(r);
        n_frames++;
        if (r.good) n_good++;
        fill = 0;
      end
    endfunction

    function void check_frame(frame_rep_t got);
      frame_rep_t want;
      if (expected_frames.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_ERRORS)
          $display("ERROR: unexpected frame report good=%0b words=%h", got.good, got.words);
        return;
      end
      want = expected_frames.pop_front();
      if (want.good !== got.good || want.words !== got.words) begin
        n_errors++;
        if (n_errors <= SHOW_ERRORS) begin
          $display("ERROR: frame_good exp %0b got %0b", want.good, got.good);
          for (int w = 0; w < sfr_pkg::WORDS; w++)
            if (want.words[w] !== got.words[w])
              $display("       payload_w%0d exp %h got %h", w, want.words[w], got.words[w]);
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  sfr_pkg::byte_t                rx_byte   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          frame_good;
  logic [31:0]                   payload_w0;
  logic [31:0]                   payload_w1;
  logic [31:0]                   payload_w2;
  logic [31:0]                   payload_w3;
  logic [31:0]                   payload_w4;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  sfr_pkg::byte_t                cfg_data  = '0;

  frame_scoreboard sb = new();
  bit  steady    = 1'b0;
  bit  hold_req  = 1'b0;
  int  cycles    = 0;
  int  n_configs = 0;

  serial_frame_receiver i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_good (frame_good),
    .payload_w0 (payload_w0),
    .payload_w1 (payload_w1),
    .payload_w2 (payload_w2),
    .payload_w3 (payload_w3),
    .payload_w4 (payload_w4),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver side: random stalls, a quiet stretch, one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 28);
      end
    end
  end

  always @(posedge clk) begin
    frame_rep_t got;
    if (!rst && out_valid && !out_stall) begin
      got.good  = frame_good;
      got.words = {payload_w4, payload_w3, payload_w2, payload_w1, payload_w0};
      sb.check_frame(got);
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_byte(sfr_pkg::byte_t b);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [sfr_pkg::CFG_IDX_W-1:0] idx, sfr_pkg::byte_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic set_config(sfr_pkg::byte_t s, sfr_pkg::byte_t e, sfr_pkg::byte_t p);
    write_reg(sfr_pkg::CFG_START, s);
    write_reg(sfr_pkg::CFG_END, e);
    write_reg(sfr_pkg::CFG_PRE_END, p);
    cfg_valid <= 1'b0;
    n_configs++;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic sfr_pkg::byte_t pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return sfr_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  function automatic sfr_pkg::byte_t noise_byte();
    case ($urandom_range(0, 4))
      0: return sb.start_b;
      1: return sb.end_b;
      2: return sb.pre_b;
      default: return sfr_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // flaw: 0 clean, 1 even check byte, 2 odd check byte, 3 pre-end byte
  function automatic void make_frame(output sfr_pkg::byte_t f [sfr_pkg::FRAME_BYTES],
                                     input int flaw, input bit extreme);
    sfr_pkg::byte_t ev;
    sfr_pkg::byte_t od;
    ev = '0;
    od = '0;
    f[0] = sb.start_b;
    for (int k = 1; k < sfr_pkg::CHECK_BYTES; k++)
      f[k] = extreme ? ((k % 2) ? 8'hFF : 8'h00) : pick_byte();
    for (int k = 0; k < sfr_pkg::CHECK_BYTES; k += 2) begin
      ev ^= f[k];
      od ^= f[k + 1];
    end
    f[20] = ev;
    f[21] = od;
    f[22] = sb.pre_b;
    f[23] = sb.end_b;
    case (flaw)
      1: f[20] ^= sfr_pkg::byte_t'($urandom_range(1, 255));
      2: f[21] ^= sfr_pkg::byte_t'($urandom_range(1, 255));
      3: f[22] ^= sfr_pkg::byte_t'($urandom_range(1, 255));
      default: ;
    endcase
  endfunction

  task automatic run_traffic(int n);
    sfr_pkg::byte_t f [sfr_pkg::FRAME_BYTES];
    int             first;
    int             r;
    int             len;
    int             flaw;
    first = sb.n_bytes;
    while (sb.n_bytes - first < n) begin
      r    = $urandom_range(0, 99);
      flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      make_frame(f, flaw, 1'b0);
      if (r < 65) begin
        len = sfr_pkg::FRAME_BYTES;
      end else if (r < 80) begin
        len = $urandom_range(1, sfr_pkg::FRAME_BYTES - 1);
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) f[k] = noise_byte();
      end
      for (int k = 0; k < len; k++) send_byte(f[k]);
    end
  endtask

  initial begin
    sfr_pkg::byte_t f [sfr_pkg::FRAME_BYTES];
    sfr_pkg::byte_t same;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // end byte into a partial window, then a clean frame with 00/FF payload;
    // the window fills one byte early and must slide without a match first
    send_byte(sb.end_b);
    make_frame(f, 0, 1'b1);
    foreach (f[k]) send_byte(f[k]);
    run_traffic(200);
    settle();

    // spare index must be ignored; extremes; no idling on either side
    write_reg(CFG_SPARE, 8'h5A);
    set_config(8'h00, 8'hFF, 8'h00);
    steady = 1'b1;
    run_traffic(250);
    settle();
    steady = 1'b0;

    set_config(8'hFF, 8'h00, 8'hFF);
    hold_req = 1'b1;
    run_traffic(250);
    settle();

    same = sfr_pkg::byte_t'($urandom_range(0, 255));
    set_config(same, same, sfr_pkg::byte_t'($urandom_range(0, 255)));
    run_traffic(250);
    settle();

    set_config(sfr_pkg::byte_t'($urandom_range(0, 255)),
               sfr_pkg::byte_t'($urandom_range(0, 255)),
               sfr_pkg::byte_t'($urandom_range(0, 255)));
    run_traffic(150);
    settle();
    run_traffic(150);
    settle();

    repeat (10) @(posedge clk);
    if (sb.expected_frames.size() != 0) begin
      sb.n_errors++;
      $display("ERROR: %0d frame reports never arrived", sb.expected_frames.size());
    end
    $display("Fed %0d bytes under %0d register settings plus reset values",
             sb.n_bytes, n_configs);
    $display("Frames reported: %0d (%0d good, %0d bad); mismatches: %0d",
             sb.n_frames, sb.n_good, sb.n_frames - sb.n_good, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
